// ----- hdl/swgm_pkg.sv -----
package swgm_pkg;

    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 31;
    localparam int unsigned COUNT_W     = 13;
    localparam int unsigned SLOT_W      = 12;
    localparam int unsigned CNT_W       = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_BAND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUID_COUNT   = 2'd2;

    localparam logic [30:0] SPHERE_RADIUS_RST = 31'd65536;
    localparam logic [30:0] WALL_BAND_RST     = 31'd6554;

    localparam logic [CNT_W-1:0] SQ_LAST   = 6'd3;
    localparam logic [CNT_W-1:0] ROOT_LAST = 6'd31;
    localparam logic [CNT_W-1:0] DIV_LAST  = 6'd32;
    localparam logic [1:0]       COORD_X   = 2'd0;
    localparam logic [1:0]       COORD_Y   = 2'd1;
    localparam logic [1:0]       COORD_Z   = 2'd2;

    localparam logic [COUNT_W-1:0] TOTAL_MAX = 13'h1FFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_TEST,
        S_MUL,
        S_PREP,
        S_DIV,
        S_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic       root_step;
        logic       decide;
        logic       mul;
        logic       prep;
        logic       div_step;
        logic       store;
        logic       out_load;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic made;
        logic zero;
        logic out_free;
    } t_status;

    function automatic logic [31:0] sat_coord(input logic [32:0] q, input logic ovf,
                                              input logic neg);
        logic [32:0] nq;
        logic [31:0] res;
        nq = ~q + 33'd1;
        if (neg) begin
            if (ovf || q > 33'h0_8000_0000) begin
                res = 32'h8000_0000;
            end else begin
                res = nq[31:0];
            end
        end else begin
            if (ovf || q > 33'h0_7FFF_FFFF) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = q[31:0];
            end
        end
        return res;
    endfunction

endpackage

// ----- hdl/swgm_ctrl.sv -----
module swgm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  swgm_pkg::t_status i_status,
    output swgm_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);

    swgm_pkg::t_state r_state, n_state;
    logic [swgm_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0] r_coord, n_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swgm_pkg::S_IDLE;
            r_cnt   <= '0;
            r_coord <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_coord <= n_coord;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swgm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = swgm_pkg::S_SQ;
                end
            end
            swgm_pkg::S_SQ: begin
                if (r_cnt == swgm_pkg::SQ_LAST) begin
                    n_state = swgm_pkg::S_ROOT;
                end
            end
            swgm_pkg::S_ROOT: begin
                if (r_cnt == swgm_pkg::ROOT_LAST) begin
                    n_state = swgm_pkg::S_TEST;
                end
            end
            swgm_pkg::S_TEST: begin
                if (i_status.made && !i_status.zero) begin
                    n_state = swgm_pkg::S_MUL;
                end else begin
                    n_state = swgm_pkg::S_OUT;
                end
            end
            swgm_pkg::S_MUL: begin
                n_state = swgm_pkg::S_PREP;
            end
            swgm_pkg::S_PREP: begin
                n_state = swgm_pkg::S_DIV;
            end
            swgm_pkg::S_DIV: begin
                if (r_cnt == swgm_pkg::DIV_LAST) begin
                    n_state = swgm_pkg::S_STORE;
                end
            end
            swgm_pkg::S_STORE: begin
                if (r_coord == swgm_pkg::COORD_Z) begin
                    n_state = swgm_pkg::S_OUT;
                end else begin
                    n_state = swgm_pkg::S_MUL;
                end
            end
            swgm_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    n_state = swgm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swgm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (n_state != r_state) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
        if (r_state == swgm_pkg::S_IDLE) begin
            n_coord = swgm_pkg::COORD_X;
        end else if (r_state == swgm_pkg::S_STORE) begin
            n_coord = r_coord + 1'b1;
        end else begin
            n_coord = r_coord;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            swgm_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            swgm_pkg::S_SQ: begin
                o_cmd.sq_step = 1'b1;
                o_cmd.idx     = r_cnt[1:0];
            end
            swgm_pkg::S_ROOT: begin
                o_cmd.root_step = 1'b1;
            end
            swgm_pkg::S_TEST: begin
                o_cmd.decide = 1'b1;
            end
            swgm_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.idx = r_coord;
            end
            swgm_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            swgm_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            swgm_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
                o_cmd.idx   = r_coord;
            end
            swgm_pkg::S_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/swgm_dp.sv -----
module swgm_dp #(
    parameter int unsigned CAPACITY = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  swgm_pkg::t_cmd                         i_cmd,
    output swgm_pkg::t_status                      o_status,
    input  logic                                   i_cfg_we,
    input  logic [swgm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [swgm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_first,
    input  logic signed [31:0]                     i_pos_x,
    input  logic signed [31:0]                     i_pos_y,
    input  logic signed [31:0]                     i_pos_z,
    input  logic [31:0]                            i_mass,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_made,
    output logic [swgm_pkg::SLOT_W-1:0]            o_slot,
    output logic signed [31:0]                     o_ghost_x,
    output logic signed [31:0]                     o_ghost_y,
    output logic signed [31:0]                     o_ghost_z,
    output logic [31:0]                            o_copy_mass,
    output logic                                   o_full_res,
    output logic [swgm_pkg::COUNT_W-1:0]           o_total_count
);

    localparam int unsigned SW = ($clog2(CAPACITY + 1) > swgm_pkg::COUNT_W) ?
                                 $clog2(CAPACITY + 1) : swgm_pkg::COUNT_W;
    localparam logic [SW-1:0] CAP = SW'(CAPACITY);

    logic [30:0]                  r_radius;
    logic [30:0]                  r_band;
    logic [swgm_pkg::COUNT_W-1:0] r_fluid;
    logic [SW-1:0]                r_next_slot;

    logic signed [31:0] r_px, r_py, r_pz;
    logic [31:0]        r_mass;
    logic [63:0]        r_prod;
    logic [63:0]        r_sum;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic               r_made;
    logic [swgm_pkg::SLOT_W-1:0] r_slot;
    logic [31:0]        r_am;
    logic               r_mneg;
    logic               r_ovf;
    logic [31:0]        r_rem;
    logic [32:0]        r_dvd;
    logic [31:0]        r_gx, r_gy, r_gz;
    logic               r_out_valid;

    logic [31:0] ax, ay, az, a_sel;
    logic        p_neg;
    logic [63:0] root_t;
    logic [31:0] root;
    logic signed [33:0] wall_gap, mir, band_s, rad_s;
    logic        made;
    logic [63:0] num;
    logic [32:0] div_t;
    logic        div_ge;
    logic [32:0] div_sub;
    logic [31:0] coord_val;
    logic [31:0] zero_z;

    assign ax = r_px[31] ? 32'(-r_px) : 32'(r_px);
    assign ay = r_py[31] ? 32'(-r_py) : 32'(r_py);
    assign az = r_pz[31] ? 32'(-r_pz) : 32'(r_pz);

    always_comb begin
        case (i_cmd.idx)
            swgm_pkg::COORD_X: begin
                a_sel = ax;
                p_neg = r_px[31];
            end
            swgm_pkg::COORD_Y: begin
                a_sel = ay;
                p_neg = r_py[31];
            end
            swgm_pkg::COORD_Z: begin
                a_sel = az;
                p_neg = r_pz[31];
            end
            default: begin
                a_sel = '0;
                p_neg = 1'b0;
            end
        endcase
    end

    assign root     = r_res[31:0];
    assign root_t   = r_res + r_bit;
    assign rad_s    = $signed({3'b000, r_radius});
    assign band_s   = $signed({3'b000, r_band});
    assign wall_gap = rad_s - $signed({2'b00, root});
    assign mir      = rad_s + wall_gap;
    assign made     = (wall_gap < band_s) && (r_next_slot < CAP);
    assign zero_z   = (mir > 34'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF : mir[31:0];

    assign num     = r_prod + {33'b0, root[31:1]};
    assign div_t   = {r_rem, r_dvd[32]};
    assign div_ge  = div_t >= {1'b0, root};
    assign div_sub = div_t - {1'b0, root};
    assign coord_val = swgm_pkg::sat_coord(r_dvd, r_ovf, p_neg ^ r_mneg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= swgm_pkg::SPHERE_RADIUS_RST;
            r_band      <= swgm_pkg::WALL_BAND_RST;
            r_fluid     <= '0;
            r_next_slot <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swgm_pkg::CFG_SPHERE_RADIUS: r_radius <= i_cfg_data;
                    swgm_pkg::CFG_WALL_BAND:     r_band   <= i_cfg_data;
                    swgm_pkg::CFG_FLUID_COUNT:   r_fluid  <= i_cfg_data[swgm_pkg::COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load && i_first) begin
                r_next_slot <= SW'(r_fluid);
            end else if (i_cmd.decide && made) begin
                r_next_slot <= r_next_slot + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
            r_mass <= i_mass;
            r_prod <= '0;
            r_sum  <= '0;
            r_res  <= '0;
            r_bit  <= 64'h4000_0000_0000_0000;
        end
        if (i_cmd.sq_step) begin
            r_prod <= a_sel * a_sel;
            r_sum  <= r_sum + r_prod;
        end
        if (i_cmd.root_step) begin
            if (r_sum >= root_t) begin
                r_sum <= r_sum - root_t;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.decide) begin
            r_made <= made;
            r_slot <= r_next_slot[swgm_pkg::SLOT_W-1:0];
            r_am   <= mir[33] ? 32'(-mir) : mir[31:0];
            r_mneg <= mir[33];
            r_gx   <= '0;
            r_gy   <= '0;
            r_gz   <= (made && root == '0) ? zero_z : 32'd0;
        end
        if (i_cmd.mul) begin
            r_prod <= a_sel * r_am;
        end
        if (i_cmd.prep) begin
            r_ovf <= {1'b0, num[63:33]} >= root;
            r_rem <= {1'b0, num[63:33]};
            r_dvd <= num[32:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_sub[31:0] : div_t[31:0];
            r_dvd <= {r_dvd[31:0], div_ge};
        end
        if (i_cmd.store) begin
            case (i_cmd.idx)
                swgm_pkg::COORD_X: r_gx <= coord_val;
                swgm_pkg::COORD_Y: r_gy <= coord_val;
                default:           r_gz <= coord_val;
            endcase
        end
        if (i_cmd.out_load) begin
            o_made        <= r_made;
            o_slot        <= r_made ? r_slot : '0;
            o_ghost_x     <= r_gx;
            o_ghost_y     <= r_gy;
            o_ghost_z     <= r_gz;
            o_copy_mass   <= r_made ? r_mass : 32'd0;
            o_full_res    <= r_next_slot >= CAP;
            o_total_count <= (r_next_slot > SW'(swgm_pkg::TOTAL_MAX)) ?
                             swgm_pkg::TOTAL_MAX : r_next_slot[swgm_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.made     = made;
    assign o_status.zero     = (root == '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

endmodule

// ----- hdl/spherical_wall_ghost_mirror_core.sv -----
// Spherical wall ghost mirror. Each request carries one particle position (signed Q15.16)
// and mass; one result comes back per request. Requests are handled one at a time: the
// three squares are taken in turn on a 32x32 multiplier, the 64-bit square root gives
// one result bit per cycle, and the wall test follows. A particle with no ghost, or one at
// the centre, goes from the wall test straight to the output. A mirrored ghost adds three
// coordinate passes (multiply, round, 33-step restoring divide, store) before the output.
// The next request is taken while a result still waits downstream.
module spherical_wall_ghost_mirror_core #(
    parameter int unsigned CAPACITY = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swgm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swgm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_first,
    input  logic signed [31:0]                  i_pos_x,
    input  logic signed [31:0]                  i_pos_y,
    input  logic signed [31:0]                  i_pos_z,
    input  logic [31:0]                         i_mass,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_made,
    output logic [swgm_pkg::SLOT_W-1:0]         o_slot,
    output logic signed [31:0]                  o_ghost_x,
    output logic signed [31:0]                  o_ghost_y,
    output logic signed [31:0]                  o_ghost_z,
    output logic [31:0]                         o_copy_mass,
    output logic                                o_full_res,
    output logic [swgm_pkg::COUNT_W-1:0]        o_total_count
);

    swgm_pkg::t_cmd    cmd;
    swgm_pkg::t_status status;

    swgm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    swgm_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_first       (i_first),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_mass        (i_mass),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_made        (o_made),
        .o_slot        (o_slot),
        .o_ghost_x     (o_ghost_x),
        .o_ghost_y     (o_ghost_y),
        .o_ghost_z     (o_ghost_z),
        .o_copy_mass   (o_copy_mass),
        .o_full_res    (o_full_res),
        .o_total_count (o_total_count)
    );

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned GHOST_CAP = 4096;
    localparam logic [swgm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                          made;
        logic [swgm_pkg::SLOT_W-1:0]   slot;
        logic [31:0]                   gx;
        logic [31:0]                   gy;
        logic [31:0]                   gz;
        logic [31:0]                   gmass;
        logic                          full;
        logic [swgm_pkg::COUNT_W-1:0]  total;
    } t_ghost;

    typedef enum logic {ROW_WR, ROW_REQ} t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic [swgm_pkg::CFG_IDX_W-1:0]   idx;
        logic [swgm_pkg::CFG_DATA_W-1:0]  data;
        logic                             first;
        logic [31:0]                      x;
        logic [31:0]                      y;
        logic [31:0]                      z;
        logic [31:0]                      mass;
        logic                             typed;
        t_ghost                           res;
    } t_stim_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [swgm_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [swgm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic                             i_first = 1'b0;
    logic signed [31:0]               i_pos_x = '0;
    logic signed [31:0]               i_pos_y = '0;
    logic signed [31:0]               i_pos_z = '0;
    logic [31:0]                      i_mass = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic                             o_made;
    logic [swgm_pkg::SLOT_W-1:0]      o_slot;
    logic signed [31:0]               o_ghost_x;
    logic signed [31:0]               o_ghost_y;
    logic signed [31:0]               o_ghost_z;
    logic [31:0]                      o_copy_mass;
    logic                             o_full_res;
    logic [swgm_pkg::COUNT_W-1:0]     o_total_count;

    longint        radius_q = 65536;
    longint        band_q = 6554;
    int unsigned   fluid_q = 0;
    int unsigned   slot_ctr = 0;

    t_ghost        pending_ghosts[$];
    t_stim_row     dir_tab[$];
    int            tx_idle_pct = 17;
    int            rx_idle_pct = 76;
    int            err_cnt = 0;
    int            n_reqs = 0;
    int            n_ghosts = 0;
    int            n_full = 0;
    int            n_writes = 0;

    spherical_wall_ghost_mirror_core #(
        .CAPACITY(GHOST_CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_first       (i_first),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_mass        (i_mass),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_made        (o_made),
        .o_slot        (o_slot),
        .o_ghost_x     (o_ghost_x),
        .o_ghost_y     (o_ghost_y),
        .o_ghost_z     (o_ghost_z),
        .o_copy_mass   (o_copy_mass),
        .o_full_res    (o_full_res),
        .o_total_count (o_total_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] mirror_axis(input longint p, input longint m,
                                                input longint unsigned r);
        longint unsigned ap;
        longint unsigned am;
        longint unsigned q;
        logic            neg;
        neg = (p < 0) != (m < 0);
        ap = (p < 0) ? -p : p;
        am = (m < 0) ? -m : m;
        q = (ap * am + (r >> 1)) / r;
        if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
        return clamp32(neg ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_ghost mirror_predict(input logic first, input logic [31:0] x,
                                              input logic [31:0] y, input logic [31:0] z,
                                              input logic [31:0] mass);
        longint          px;
        longint          py;
        longint          pz;
        longint          gap;
        longint          mir;
        longint unsigned sum;
        longint unsigned r;
        t_ghost          g;
        if (first) slot_ctr = fluid_q;
        px = $signed(x);
        py = $signed(y);
        pz = $signed(z);
        sum = px * px + py * py + pz * pz;
        r = int_sqrt(sum);
        gap = radius_q - longint'(r);
        g = '0;
        if (gap < band_q && slot_ctr < GHOST_CAP) begin
            mir = radius_q + gap;
            g.made = 1'b1;
            g.slot = slot_ctr[swgm_pkg::SLOT_W-1:0];
            if (sum == 0) begin
                g.gz = clamp32(mir);
            end else begin
                g.gx = mirror_axis(px, mir, r);
                g.gy = mirror_axis(py, mir, r);
                g.gz = mirror_axis(pz, mir, r);
            end
            g.gmass = mass;
            slot_ctr = slot_ctr + 1;
        end
        g.full = (slot_ctr >= GHOST_CAP);
        g.total = (slot_ctr > 8191) ? swgm_pkg::TOTAL_MAX : slot_ctr[swgm_pkg::COUNT_W-1:0];
        return g;
    endfunction

    function automatic t_stim_row wr_row(input logic [swgm_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [swgm_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '0;
        row.kind = ROW_WR;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic t_stim_row req_row(input logic first, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z,
                                          input logic [31:0] mass);
        t_stim_row row;
        row = '0;
        row.kind = ROW_REQ;
        row.first = first;
        row.x = x;
        row.y = y;
        row.z = z;
        row.mass = mass;
        return row;
    endfunction

    function automatic t_stim_row chk_row(input logic first, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z,
                                          input logic [31:0] mass, input logic made,
                                          input logic [swgm_pkg::SLOT_W-1:0] slot,
                                          input logic [31:0] gx, input logic [31:0] gy,
                                          input logic [31:0] gz, input logic full,
                                          input logic [swgm_pkg::COUNT_W-1:0] total);
        t_stim_row row;
        row = req_row(first, x, y, z, mass);
        row.typed = 1'b1;
        row.res.made = made;
        row.res.slot = slot;
        row.res.gx = gx;
        row.res.gy = gy;
        row.res.gz = gz;
        row.res.gmass = made ? mass : 32'h0;
        row.res.full = full;
        row.res.total = total;
        return row;
    endfunction

    function automatic void add_row(input t_stim_row row);
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : result_mon
        t_ghost want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_ghosts.size() == 0) begin
                $error("result with no request outstanding");
                err_cnt++;
            end else begin
                want = pending_ghosts.pop_front();
                check_field("made", 32'(want.made), 32'(o_made));
                check_field("slot", 32'(want.slot), 32'(o_slot));
                check_field("ghost_x", want.gx, o_ghost_x);
                check_field("ghost_y", want.gy, o_ghost_y);
                check_field("ghost_z", want.gz, o_ghost_z);
                check_field("copy_mass", want.gmass, o_copy_mass);
                check_field("full_res", 32'(want.full), 32'(o_full_res));
                check_field("total_count", 32'(want.total), 32'(o_total_count));
                if (want.made) n_ghosts++;
                if (want.full) n_full++;
            end
        end
    end

    task automatic send_req(input logic first, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] mass,
                            input logic typed, input t_ghost typed_res);
        t_ghost pred;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first <= first;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_mass <= mass;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pred = mirror_predict(first, x, y, z, mass);
        pending_ghosts.insert(pending_ghosts.size(), typed ? typed_res : pred);
        n_reqs++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_ghosts.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [swgm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swgm_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            swgm_pkg::CFG_SPHERE_RADIUS: radius_q = data;
            swgm_pkg::CFG_WALL_BAND:     band_q = data;
            swgm_pkg::CFG_FLUID_COUNT:   fluid_q = data[swgm_pkg::COUNT_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic pick_setting();
        logic [swgm_pkg::CFG_DATA_W-1:0] rad;
        logic [swgm_pkg::CFG_DATA_W-1:0] band;
        logic [swgm_pkg::CFG_DATA_W-1:0] fc;
        case ($urandom_range(5))
            0: rad = 31'd65536;
            1: rad = '0;
            2: rad = 31'h7FFF_FFFF;
            3: rad = 31'($urandom_range(32'h0010_0000, 1));
            default: rad = 31'($urandom);
        endcase
        case ($urandom_range(5))
            0: band = '0;
            1: band = 31'h7FFF_FFFF;
            2: band = rad >> 3;
            3: band = 31'($urandom_range(65536));
            4: band = rad >> 1;
            default: band = 31'($urandom);
        endcase
        case ($urandom_range(5))
            0: fc = '0;
            1: fc = 31'($urandom_range(4095));
            2: fc = 31'($urandom_range(4096, 4000));
            3: fc = 31'(GHOST_CAP);
            4: fc = 31'($urandom_range(8191, 4097));
            default: fc = 31'($urandom_range(4095, 4080));
        endcase
        settle();
        cfg_write(swgm_pkg::CFG_SPHERE_RADIUS, rad);
        cfg_write(swgm_pkg::CFG_WALL_BAND, band);
        cfg_write(swgm_pkg::CFG_FLUID_COUNT, fc);
    endtask

    task automatic send_random();
        longint          c[3];
        longint          dv[3];
        longint          tgt;
        longint          off;
        longint unsigned len;
        logic            first;
        logic [31:0]     mass;
        int              k;
        first = ($urandom_range(99) < 3);
        tgt = 0;
        c[0] = 0;
        c[1] = 0;
        c[2] = 0;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                off = longint'($urandom) % (band_q + 2);
                tgt = ($urandom_range(2) == 0) ? radius_q + off / 4 : radius_q - off;
                if (tgt < 0) tgt = 0;
                if (tgt > 64'sd2147483647) tgt = 64'sd2147483647;
                for (k = 0; k < 3; k++) dv[k] = longint'($urandom_range(65535)) - 32768;
                len = int_sqrt(dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2]);
                if (len == 0) begin
                    dv[2] = 1;
                    len = 1;
                end
                for (k = 0; k < 3; k++) c[k] = dv[k] * tgt / longint'(len);
            end
            10, 11, 12, 13: begin
                for (k = 0; k < 3; k++) c[k] = $urandom;
            end
            14, 15: begin
                for (k = 0; k < 3; k++) begin
                    c[k] = longint'($urandom) % (radius_q + 1) - radius_q / 2;
                end
            end
            16: begin
                k = $urandom_range(3);
                if (k < 3) c[k] = $urandom_range(1) ? radius_q : -radius_q;
            end
            default: begin
                for (k = 0; k < 3; k++) begin
                    case ($urandom_range(6))
                        0: c[k] = 32'h8000_0000;
                        1: c[k] = 32'h7FFF_FFFF;
                        2: c[k] = 0;
                        3: c[k] = -1;
                        4: c[k] = 1;
                        5: c[k] = radius_q;
                        default: c[k] = -radius_q;
                    endcase
                end
            end
        endcase
        case ($urandom_range(9))
            0: mass = 32'h0;
            1: mass = 32'hFFFF_FFFF;
            default: mass = $urandom;
        endcase
        send_req(first, c[0][31:0], c[1][31:0], c[2][31:0], mass, 1'b0, '0);
    endtask

    initial begin : stimulus
        int ph;
        int seg;
        add_row(chk_row(0, 0, 0, 0, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0));
        add_row(chk_row(0, 65536, 0, 0, 32'hFFFF_FFFF, 1, 0, 65536, 0, 0, 0, 1));
        add_row(req_row(0, 0, -65000, 0, 32'h0));
        add_row(req_row(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
        add_row(req_row(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hA5A5_A5A5));
        add_row(req_row(0, 12345, -54321, 40000, 32'h0F0F_0F0F));
        add_row(req_row(0, 46341, 46341, 0, 32'h1));
        add_row(wr_row(swgm_pkg::CFG_WALL_BAND, '0));
        add_row(chk_row(1, 65536, 0, 0, 32'h5555_5555, 0, 0, 0, 0, 0, 0, 0));
        add_row(wr_row(swgm_pkg::CFG_SPHERE_RADIUS, '0));
        add_row(chk_row(0, 65536, -2, 3, 32'h1, 1, 0, 32'hFFFF_0000, 2,
                        32'hFFFF_FFFD, 0, 1));
        add_row(chk_row(0, 0, 0, 0, 32'h2, 0, 0, 0, 0, 0, 0, 1));
        add_row(wr_row(swgm_pkg::CFG_SPHERE_RADIUS, 31'h7FFF_FFFF));
        add_row(wr_row(swgm_pkg::CFG_WALL_BAND, 31'h7FFF_FFFF));
        add_row(chk_row(0, 1, 0, 0, 32'h3, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 2));
        add_row(chk_row(0, -1, 0, 0, 32'h4, 1, 2, 32'h8000_0000, 0, 0, 0, 3));
        add_row(chk_row(0, 0, 0, 0, 32'h5, 0, 0, 0, 0, 0, 0, 3));
        add_row(wr_row(swgm_pkg::CFG_SPHERE_RADIUS, 31'h7FFF_FFFE));
        add_row(chk_row(0, 0, 0, 0, 32'h6, 1, 3, 0, 0, 32'h7FFF_FFFF, 0, 4));
        add_row(wr_row(swgm_pkg::CFG_SPHERE_RADIUS, 31'd65536));
        add_row(wr_row(swgm_pkg::CFG_WALL_BAND, 31'd6554));
        add_row(wr_row(swgm_pkg::CFG_FLUID_COUNT, 31'd4095));
        add_row(chk_row(1, 0, 65536, 0, 32'h7, 1, 12'hFFF, 0, 65536, 0, 1, 4096));
        add_row(chk_row(0, 0, 0, -65536, 32'h8, 0, 0, 0, 0, 0, 1, 4096));
        add_row(wr_row(swgm_pkg::CFG_FLUID_COUNT, 31'd8191));
        add_row(chk_row(1, 65536, 0, 0, 32'h9, 0, 0, 0, 0, 0, 1, 8191));
        add_row(wr_row(CFG_SPARE, 31'h7FFF_FFFF));
        add_row(wr_row(swgm_pkg::CFG_FLUID_COUNT, '0));
        add_row(chk_row(1, 0, 0, 65536, 32'hA, 1, 0, 0, 0, 65536, 0, 1));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_WR) begin
                settle();
                cfg_write(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_req(dir_tab[i].first, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                         dir_tab[i].mass, dir_tab[i].typed, dir_tab[i].res);
            end
        end

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 76 : 0;
            rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 17 : 0;
            for (seg = 0; seg < 6; seg++) begin
                pick_setting();
                repeat (95) send_random();
            end
        end

        settle();
        repeat (300) @(negedge i_clk);
        $display("Sent %0d particles over %0d register writes and three stall patterns.",
                 n_reqs, n_writes);
        $display("%0d ghosts made, %0d results with the slot counter full.", n_ghosts, n_full);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
